// ----- rtl/fcn_pkg.sv -----
// Shared types and constants for the FIR filter with coefficient nudge.
// Holds field widths, item structs, register indexes and fixed-point limits.
// No dependencies.
package fcn_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int STEP_W     = 15;
  localparam int TAP_CNT_W  = 7;
  localparam int IDX_W      = 6;
  localparam int SUM_W      = 24;
  localparam int DELTA_W    = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int FRAC_BITS  = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int DEFAULT_MAX_TAPS = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNCHECKED = 2'd2;

  // operation / result kind codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_ADJUST = 1'b1;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 7'd5;
  localparam logic [STEP_W-1:0]    STEP_SIZE_RST = 15'd1638;

  localparam int COEF_MAX   = 131071;
  localparam int COEF_MIN   = -131072;
  localparam int UNITY      = 16384;
  localparam int ROUND_BIAS = 8192;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  typedef struct packed {
    logic                       operation;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [IDX_W-1:0]           tap_index;
    logic                       raise;
  } fcn_in_t;

  typedef struct packed {
    logic                       result_kind;
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic                       adjust_accepted;
  } fcn_out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                      clear;
    logic                      op;
    logic                      apply;
    logic [IDX_W-1:0]          idx;
    logic signed [DELTA_W-1:0] delta;
  } fcn_ctrl_t;

endpackage

// ----- rtl/fcn_cell.sv -----
// One tap cell: delay-line stage, coefficient, registered product and token stage.
// Depends on fcn_pkg.
module fcn_cell #(
  parameter int INDEX = 0,
  parameter int ACC_W = fcn_pkg::PROD_W
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                shift_en,
  input  logic signed [fcn_pkg::SAMPLE_W-1:0] sample_prev,
  input  fcn_pkg::fcn_ctrl_t                  ctrl,
  input  logic                                tok_valid_in,
  input  logic signed [ACC_W-1:0]             tok_acc_in,
  output logic signed [fcn_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                tok_valid_out,
  output logic signed [ACC_W-1:0]             tok_acc_out
);
  import fcn_pkg::*;

  logic signed [SAMPLE_W-1:0] sample;
  logic signed [COEF_W-1:0]   coef;
  logic signed [PROD_W-1:0]   prod;
  logic                       tok_valid;
  logic signed [ACC_W-1:0]    tok_acc;

  logic                       match;
  logic signed [COEF_W:0]     raw;
  logic signed [COEF_W-1:0]   coef_next;
  logic signed [COEF_W:0]     change;
  logic signed [ACC_W-1:0]    addend;

  always_comb begin
    match = tok_valid_in && (ctrl.op == OP_ADJUST) && ctrl.apply
            && (int'(ctrl.idx) == INDEX);
    raw = $signed({coef[COEF_W-1], coef}) + (COEF_W+1)'(ctrl.delta);
    if (raw > COEF_MAX) begin
      coef_next = COEF_W'(COEF_MAX);
    end else if (raw < COEF_MIN) begin
      coef_next = COEF_W'(COEF_MIN);
    end else begin
      coef_next = COEF_W'(raw);
    end
    change = $signed({coef_next[COEF_W-1], coef_next}) - $signed({coef[COEF_W-1], coef});
    // filter tokens gather products, adjust tokens gather the coefficient change
    if (ctrl.op == OP_ADJUST) begin
      addend = match ? ACC_W'(change) : '0;
    end else begin
      addend = ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample    <= '0;
      coef      <= '0;
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_valid_in;
      if (shift_en) begin
        sample <= sample_prev;
      end
      if (ctrl.clear) begin
        coef <= '0;
      end else if (match) begin
        coef <= coef_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod    <= sample * coef;
    tok_acc <= tok_acc_in + addend;
  end

  assign sample_out    = sample;
  assign tok_valid_out = tok_valid;
  assign tok_acc_out   = tok_acc;

endmodule

// ----- rtl/fir_filter_with_coefficient_nudge_unit.sv -----
// Top level of the direct-form FIR filter with coefficient nudge.
// Controller, register file and output stage around a row of fcn_cell; uses fcn_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in      | in        | in_valid/in_ready  | in_item  (fcn_in_t)
//   out     | out       | out_valid/out_ready| out_item (fcn_out_t)
//   cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each item passes from acceptance through the launch registers launch_a and
// launch_b, then through every cell as the token walks the tap chain, and into
// the capture stage before the output register. One item is in the chain at a time.
// rst is synchronous: delay line, coefficients and coefficient sum clear, and
// the registers return to tap_count 5, step 1638, checked mode.
// A stalled output holds in the output register; the next item is taken as
// soon as the chain and the capture stage are free. cfg is always ready.
module fir_filter_with_coefficient_nudge_unit #(
  parameter int MAX_TAPS = fcn_pkg::DEFAULT_MAX_TAPS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fcn_pkg::fcn_in_t                   in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fcn_pkg::fcn_out_t                  out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fcn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcn_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fcn_pkg::*;

  // exact sum of MAX_TAPS products
  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
  localparam int Q_W   = ACC_W + 1 - FRAC_BITS;

  // configuration registers
  logic [TAP_CNT_W-1:0]     tap_count;
  logic [STEP_W-1:0]        step_size;
  logic                     unchecked_mode;
  logic signed [SUM_W-1:0]  coef_sum;

  // item held for the chain
  logic                      op_q;
  logic                      apply_q;
  logic [IDX_W-1:0]          idx_q;
  logic signed [DELTA_W-1:0] delta_q;

  // sequencing
  logic                      running;
  logic                      launch_a;
  logic                      launch_b;
  logic                      done_valid;
  logic signed [ACC_W-1:0]   done_acc;

  logic                      in_fire;
  logic                      cfg_fire;
  logic                      out_load;
  fcn_ctrl_t                 ctrl;

  // per-cell links
  logic signed [SAMPLE_W-1:0] samp [MAX_TAPS+1];
  logic                       tv   [MAX_TAPS+1];
  logic signed [ACC_W-1:0]    tacc [MAX_TAPS+1];

  // adjust decision
  logic signed [DELTA_W-1:0]  delta;
  logic signed [SUM_W:0]      sum_try;
  logic                       idx_ok;
  logic                       apply;

  // rounding
  logic signed [ACC_W:0]      rnd;
  logic signed [Q_W-1:0]      q;
  logic signed [SAMPLE_W-1:0] y;

  assign in_ready  = !running && !done_valid;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_load  = done_valid && (!out_valid || out_ready);

  always_comb begin
    delta   = in_item.raise ? $signed({1'b0, step_size}) : -$signed({1'b0, step_size});
    sum_try = (SUM_W+1)'(coef_sum) + (SUM_W+1)'(delta);
    idx_ok  = (int'(in_item.tap_index) < int'(tap_count))
              && (int'(in_item.tap_index) < MAX_TAPS);
    apply   = idx_ok && (unchecked_mode || ((sum_try <= UNITY) && (sum_try >= -UNITY)));
  end

  assign ctrl = '{clear: cfg_fire && (cfg_index == CFG_TAP_COUNT),
                  op:    op_q,
                  apply: apply_q,
                  idx:   idx_q,
                  delta: delta_q};

  // tap chain: sample enters cell 0, token walks from cell 0 to the last cell
  assign samp[0] = in_item.sample_in;
  assign tv[0]   = launch_b;
  assign tacc[0] = '0;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    fcn_cell #(
      .INDEX (k),
      .ACC_W (ACC_W)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .shift_en      (in_fire && (in_item.operation == OP_FILTER)),
      .sample_prev   (samp[k]),
      .ctrl          (ctrl),
      .tok_valid_in  (tv[k]),
      .tok_acc_in    (tacc[k]),
      .sample_out    (samp[k+1]),
      .tok_valid_out (tv[k+1]),
      .tok_acc_out   (tacc[k+1])
    );
  end

  // round half up, then saturate to 16 bits
  always_comb begin
    rnd = (ACC_W+1)'(done_acc) + (ACC_W+1)'(ROUND_BIAS);
    q   = Q_W'(rnd >>> FRAC_BITS);
    if (q > SAMPLE_MAX) begin
      y = SAMPLE_W'(SAMPLE_MAX);
    end else if (q < SAMPLE_MIN) begin
      y = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      y = SAMPLE_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count      <= TAP_COUNT_RST;
      step_size      <= STEP_SIZE_RST;
      unchecked_mode <= 1'b0;
      coef_sum       <= '0;
      running        <= 1'b0;
      launch_a       <= 1'b0;
      launch_b       <= 1'b0;
      done_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // launch goes through launch_a and launch_b so cell products see the shifted delay line
      launch_a <= in_fire;
      launch_b <= launch_a;
      if (in_fire) begin
        running <= 1'b1;
      end else if (tv[MAX_TAPS]) begin
        running <= 1'b0;
      end

      if (tv[MAX_TAPS]) begin
        done_valid <= 1'b1;
        if (op_q == OP_ADJUST) begin
          // token carries the change that actually happened
          coef_sum <= coef_sum + SUM_W'(tacc[MAX_TAPS]);
        end
      end else if (out_load) begin
        done_valid <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_TAP_COUNT: begin
            if (cfg_data[TAP_CNT_W-1:0] == '0) begin
              tap_count <= TAP_CNT_W'(1);
            end else if (int'(cfg_data[TAP_CNT_W-1:0]) > MAX_TAPS) begin
              tap_count <= TAP_CNT_W'(MAX_TAPS);
            end else begin
              tap_count <= cfg_data[TAP_CNT_W-1:0];
            end
            coef_sum <= '0;
          end
          CFG_STEP_SIZE: step_size      <= cfg_data[STEP_W-1:0];
          CFG_UNCHECKED: unchecked_mode <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q    <= in_item.operation;
      apply_q <= (in_item.operation == OP_ADJUST) && apply;
      idx_q   <= in_item.tap_index;
      delta_q <= delta;
    end
    if (tv[MAX_TAPS]) begin
      done_acc <= tacc[MAX_TAPS];
    end
    if (out_load) begin
      out_item.result_kind     <= op_q;
      out_item.filtered_sample <= (op_q == OP_FILTER) ? y : '0;
      out_item.adjust_accepted <= (op_q == OP_ADJUST) && apply_q;
    end
  end

endmodule

// ----- rtl/fcn_checker.sv -----
// Port-level checks for the FIR filter with coefficient nudge, bound to the top.
// Depends on fcn_pkg and fir_filter_with_coefficient_nudge_unit.
module fcn_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input fcn_pkg::fcn_out_t out_item
);
  import fcn_pkg::*;

  // one item in flight: after an accept the input closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // nothing in flight and no result shown: no result can appear next cycle
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (in_ready && !out_valid) |=> !out_valid)
    else $error("result without an item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.result_kind == OP_FILTER) ? !out_item.adjust_accepted
                                                        : (out_item.filtered_sample == '0)))
    else $error("result fields do not match result kind");

endmodule

bind fir_filter_with_coefficient_nudge_unit fcn_checker u_fcn_checker (.*);
